// ===== hdl/gwm_pkg.sv =====
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package gwm_pkg;

    localparam int MAX_PAT_BYTES_DEF = 16;   // default pattern capacity
    localparam int PAT_BYTES         = 16;   // bytes held by the two pattern registers
    localparam int LEN_W             = 5;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 2;

    localparam logic [7:0] CHAR_ANY_RUN = 8'h2A;   // '*'
    localparam logic [7:0] CHAR_ANY_ONE = 8'h3F;   // '?'
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] UPPER_Z      = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_PAT_LEN  = 2'd2,
        REG_CASE     = 2'd3
    } t_cfg_idx;

    // settings seen by the matching logic
    typedef struct packed {
        logic [PAT_BYTES-1:0][7:0] pat;      // raw pattern bytes, byte 0 at index 0
        logic [LEN_W-1:0]          len;      // clamped length
        logic                      case_sens;
        logic                      restart;  // one-cycle pulse after any register write
    } t_pat_cfg;

    function automatic logic [7:0] f_fold(input logic [7:0] c, input logic case_sens);
        logic [7:0] r;
        r = c;
        if (!case_sens && c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/glob_wildcard_matcher_core.sv =====
// Top level of the glob wildcard matcher: input stage, result register,
// configuration port. Depends on gwm_pkg, gwm_cfg and gwm_nfa.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_name_byte, i_byte_valid, i_last_byte
//  out      from block o_out_valid / i_out_stall o_matched
//  cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle while a stalled result does not hold a last item: an item
// sits in the input register, where the position vector is advanced, and the
// verdict of a last item lands in the result register at the edge that retires it.
// The combinational position update (compare, shift, star ripple) sets the rate.
// Reset restores the register defaults (empty pattern, case sensitive).
// A stalled result holds the input stage only when that stage holds a last item.
`default_nettype none

module glob_wildcard_matcher_core #(
    parameter int MAX_PATTERN_BYTES = gwm_pkg::MAX_PAT_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_name_byte,
    input  wire logic                           i_byte_valid,
    input  wire logic                           i_last_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_matched,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gwm_pkg::*;

    t_pat_cfg   w_cfg;
    logic       w_accept;
    logic       w_adv;
    logic       w_out_free;
    logic       w_verdict;

    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_bvld;
    logic       r_last;
    logic       r_out_vld;
    logic       r_matched;

    assign o_cfg_ready = 1'b1;

    gwm_cfg #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    gwm_nfa #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_nfa (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_advance  (w_adv),
        .i_byte     (r_byte),
        .i_byte_vld (r_bvld),
        .i_last     (r_last),
        .o_matched  (w_verdict)
    );

    // only a last item needs room in the result register
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_adv      = r_in_vld && (!r_last || w_out_free);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv && r_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_name_byte;
            r_bvld <= i_byte_valid;
            r_last <= i_last_byte;
        end
        if (w_adv && r_last) begin
            r_matched <= w_verdict;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_matched   = r_matched;

    // a result appears only from a last item leaving the input stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_adv && r_last))
        else $error("result without a last item");

    // an empty pattern matches every name
    a_empty_pat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_last && w_cfg.len == '0) |=> o_matched)
        else $error("empty pattern gave no match");

    // a held item in the input stage keeps its byte
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_byte) && $stable(r_last)))
        else $error("held item changed");

endmodule

`default_nettype wire

// ===== hdl/gwm_cfg.sv =====
// Configuration register file of the glob wildcard matcher.
// Depends on gwm_pkg; feeds the t_pat_cfg struct to the position tracker.
`default_nettype none

module gwm_cfg #(
    parameter int MAX_PATTERN_BYTES = gwm_pkg::MAX_PAT_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0] i_idx,
    input  wire logic [gwm_pkg::CFG_DATA_W-1:0] i_data,
    output gwm_pkg::t_pat_cfg                  o_cfg
);
    import gwm_pkg::*;

    logic [CFG_DATA_W-1:0] r_pat_lo;
    logic [CFG_DATA_W-1:0] r_pat_hi;
    logic [LEN_W-1:0]      r_len;
    logic                  r_case;
    logic                  r_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_len    <= '0;
            r_case   <= 1'b1;
            r_wr     <= 1'b0;
        end else begin
            r_wr <= i_wr;
            if (i_wr) begin
                case (t_cfg_idx'(i_idx))
                    REG_PAT_LOW:  r_pat_lo <= i_data;
                    REG_PAT_HIGH: r_pat_hi <= i_data;
                    REG_PAT_LEN:  r_len    <= i_data[LEN_W-1:0];
                    REG_CASE:     r_case   <= i_data[0];
                    default:      r_case   <= r_case;
                endcase
            end
        end
    end

    always_comb begin
        o_cfg.pat       = {r_pat_hi, r_pat_lo};
        o_cfg.len       = (r_len > LEN_W'(MAX_PATTERN_BYTES)) ? LEN_W'(MAX_PATTERN_BYTES) : r_len;
        o_cfg.case_sens = r_case;
        o_cfg.restart   = r_wr;
    end

endmodule

`default_nettype wire

// ===== hdl/gwm_nfa.sv =====
// Active-position tracker: holds the star-closed position vector and advances
// it by one name byte per item. Depends on gwm_pkg.
`default_nettype none

module gwm_nfa #(
    parameter int MAX_PATTERN_BYTES = gwm_pkg::MAX_PAT_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gwm_pkg::t_pat_cfg i_cfg,
    input  wire logic              i_advance,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_byte_vld,
    input  wire logic              i_last,
    output logic                   o_matched
);
    import gwm_pkg::*;

    localparam int VW = MAX_PATTERN_BYTES + 1;

    logic [VW-1:0]                r_active;
    logic [VW-1:0]                n_active;
    logic [VW-1:0]                w_keep;
    logic [VW-1:0]                w_end;
    logic [VW-1:0]                w_step;
    logic [VW-1:0]                w_after;
    logic [VW-1:0]                w_restart;
    logic [MAX_PATTERN_BYTES-1:0] w_star;
    logic [MAX_PATTERN_BYTES-1:0] w_hit;
    logic [7:0]                   w_c;
    logic [7:0]                   w_p;

    // a set position followed by '*' also sets the next one; ripples through star runs
    function automatic logic [VW-1:0] f_closure(input logic [VW-1:0] v,
                                                input logic [MAX_PATTERN_BYTES-1:0] s);
        logic [VW-1:0] x;
        x = v;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            x[i+1] = x[i+1] | (x[i] & s[i]);
        end
        return x;
    endfunction

    always_comb begin
        w_c = f_fold(i_byte, i_cfg.case_sens);
        w_p = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            w_p       = f_fold(i_cfg.pat[i], i_cfg.case_sens);
            w_star[i] = (LEN_W'(i) < i_cfg.len) && (w_p == CHAR_ANY_RUN);
            w_hit[i]  = (LEN_W'(i) < i_cfg.len) && (w_p != CHAR_ANY_RUN)
                        && (w_p == CHAR_ANY_ONE || w_p == w_c);
        end
        for (int j = 0; j < VW; j++) begin
            w_keep[j] = (LEN_W'(j) <= i_cfg.len);
            w_end[j]  = (LEN_W'(j) == i_cfg.len);
        end

        // '*' stays put, a matching byte moves one position on
        w_step = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            w_step[i]   = w_step[i]   | (r_active[i] & w_star[i]);
            w_step[i+1] = w_step[i+1] | (r_active[i] & w_hit[i]);
        end

        w_restart = f_closure(VW'(1), w_star) & w_keep;
        w_after   = i_byte_vld ? (f_closure(w_step, w_star) & w_keep) : r_active;
        o_matched = (i_cfg.len == '0) ? 1'b1 : |(w_after & w_end);

        n_active = r_active;
        if (i_cfg.restart) begin
            n_active = w_restart;
        end else if (i_advance) begin
            n_active = i_last ? w_restart : w_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= VW'(1);
        end else begin
            r_active <= n_active;
        end
    end

endmodule

`default_nettype wire
